@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/ftpq_pkg.sv @@
// ----------------------------------------------------------------------------
// ftpq_pkg
// types, sizes and codes for the tie-break priority queue
// ----------------------------------------------------------------------------
package ftpq_pkg;

  localparam int DEPTH       = 64;
  localparam int TAG_BITS    = 16;
  localparam int PRIO_BITS   = 8;
  localparam int STAMP_BITS  = 32;
  localparam int KIND_BITS   = 2;
  localparam int STATUS_BITS = 3;
  localparam int SLOT_BITS   = $clog2(DEPTH);
  localparam int COUNT_BITS  = $clog2(DEPTH + 1);
  localparam int LEVELS      = $clog2(DEPTH);
  localparam int SRCH_BITS   = $clog2(LEVELS + 1);
  localparam int KEY_BITS    = STAMP_BITS + SLOT_BITS;
  localparam int ORDER_BITS  = PRIO_BITS + STAMP_BITS + SLOT_BITS;
  localparam int NODES       = 2 * DEPTH - 1;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_INSERT  = 2'd0,
    KIND_REMOVE  = 2'd1,
    KIND_UPGRADE = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_NOTAG  = 3'd2,
    ST_URGENT = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_FLAG,
    S_APPLY,
    S_RESULT
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_FLAG,
    CELL_APPLY,
    CELL_REMOVE,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    logic                  valid;
    logic [TAG_BITS-1:0]   tag;
    logic [PRIO_BITS-1:0]  prio;
    logic [STAMP_BITS-1:0] stamp;
    logic [SLOT_BITS-1:0]  slot;
  } entry_t;

  typedef struct packed {
    cell_op_t              op;
    logic                  upgrade;
    entry_t                ent;
    logic [ORDER_BITS-1:0] old_key;
  } cell_ctrl_t;

  typedef struct packed {
    logic                 valid;
    logic [KEY_BITS-1:0]  key;
    logic [PRIO_BITS-1:0] prio;
  } node_t;

  // sort key of the chain: priority, then stamp, then slot
  function automatic logic [ORDER_BITS-1:0] order_key(entry_t e);
    return {e.prio, e.stamp, e.slot};
  endfunction

endpackage

@@ design/ftpq_cell.sv @@
// ----------------------------------------------------------------------------
// ftpq_cell
// one position of the sorted entry chain
// ----------------------------------------------------------------------------
module ftpq_cell (
  input  logic                clk,
  input  logic                rst,
  input  ftpq_pkg::cell_ctrl_t ctrl,
  input  ftpq_pkg::entry_t    prev_entry,
  input  ftpq_pkg::entry_t    next_entry,
  input  logic                prev_move,
  output ftpq_pkg::entry_t    entry,
  output logic                move
);
  import ftpq_pkg::*;

  logic                  hit;
  logic [ORDER_BITS-1:0] my_key;
  logic [ORDER_BITS-1:0] new_key;

  assign my_key  = order_key(entry);
  assign new_key = order_key(ctrl.ent);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
      move        <= 1'b0;
      hit         <= 1'b0;
    end else begin
      case (ctrl.op)
        CELL_FLAG: begin
          if (ctrl.upgrade) begin
            move <= entry.valid && (new_key < my_key) && (my_key <= ctrl.old_key);
            hit  <= entry.valid && (entry.slot == ctrl.old_key[SLOT_BITS-1:0]);
          end else begin
            move <= !entry.valid || (new_key < my_key);
            hit  <= 1'b0;
          end
        end
        CELL_APPLY: begin
          if (move && !prev_move) begin
            entry <= ctrl.ent;
          end else if (move) begin
            entry <= prev_entry;
          end else if (hit) begin
            entry <= ctrl.ent;
          end
        end
        CELL_REMOVE: entry <= next_entry;
        CELL_CLEAR:  entry.valid <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

@@ design/ftpq_min_tree.sv @@
// ----------------------------------------------------------------------------
// ftpq_min_tree
// registered minimum tree, one level per cycle after load
// ----------------------------------------------------------------------------
module ftpq_min_tree (
  input  logic            clk,
  input  logic            load,
  input  ftpq_pkg::node_t leaf [ftpq_pkg::DEPTH],
  output ftpq_pkg::node_t root
);
  import ftpq_pkg::*;

  node_t node [NODES];

  function automatic node_t pick(node_t a, node_t b);
    if (a.valid && (!b.valid || a.key <= b.key)) begin
      return a;
    end
    return b;
  endfunction

  always_ff @(posedge clk) begin
    for (int n = 0; n < DEPTH - 1; n++) begin
      node[n] <= pick(node[2*n+1], node[2*n+2]);
    end
    if (load) begin
      for (int j = 0; j < DEPTH; j++) begin
        node[DEPTH-1+j] <= leaf[j];
      end
    end
  end

  assign root = node[0];

endmodule

@@ design/fifo_tiebreak_priority_queue.sv @@
// ----------------------------------------------------------------------------
// fifo_tiebreak_priority_queue
// bounded priority queue, sorted cell chain with oldest-first tie-break
// ----------------------------------------------------------------------------
// remove and clear: the request passes the apply and result states
// insert and upgrade: search, decide, flag, apply and result states, with the
//   min-tree search over the slots; a new request waits until the result is out
// early status (full, empty, tag not found, more urgent) returns sooner
// reset: synchronous, clears all valid bits, count and stamp counter at once
module fifo_tiebreak_priority_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ftpq_pkg::KIND_BITS-1:0]  kind,
  input  logic [ftpq_pkg::TAG_BITS-1:0]   tag,
  input  logic [ftpq_pkg::PRIO_BITS-1:0]  priority_req,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ftpq_pkg::STATUS_BITS-1:0] status,
  output logic [ftpq_pkg::TAG_BITS-1:0]   removed_tag,
  output logic [ftpq_pkg::TAG_BITS-1:0]   front_tag,
  output logic [ftpq_pkg::PRIO_BITS-1:0]  front_priority,
  output logic                            queue_empty,
  output logic [ftpq_pkg::COUNT_BITS-1:0] entry_count
);
  import ftpq_pkg::*;

  state_t                state, state_next;
  kind_t                 kind_in, kind_q;
  logic [TAG_BITS-1:0]   tag_q;
  logic [PRIO_BITS-1:0]  prio_q;
  status_t               status_q;
  logic [TAG_BITS-1:0]   removed_q;
  logic [DEPTH-1:0]      used;
  logic [COUNT_BITS-1:0] count;
  logic [STAMP_BITS-1:0] arrival;
  logic [SRCH_BITS-1:0]  srch;
  entry_t                new_ent;
  logic [ORDER_BITS-1:0] old_key_q;
  cell_ctrl_t            cell_ctrl;
  cell_op_t              cell_op;
  logic                  accept;
  logic                  out_free;

  entry_t                ent      [DEPTH];
  entry_t                prev_ent [DEPTH];
  entry_t                next_ent [DEPTH];
  logic [DEPTH-1:0]      mv;
  logic [DEPTH-1:0]      prev_mv;
  node_t                 leaf     [DEPTH];
  node_t                 root;

  assign kind_in  = kind_t'(kind);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // neighbor wiring of the chain
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      prev_ent[i] = (i == 0) ? '0 : ent[(i == 0) ? 0 : i - 1];
      next_ent[i] = (i == DEPTH - 1) ? '0 : ent[(i == DEPTH - 1) ? i : i + 1];
      prev_mv[i]  = (i == 0) ? 1'b0 : mv[(i == 0) ? 0 : i - 1];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ftpq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl),
      .prev_entry (prev_ent[g]),
      .next_entry (next_ent[g]),
      .prev_move  (prev_mv[g]),
      .entry      (ent[g]),
      .move       (mv[g])
    );
  end

  // search leaves: oldest tag match for upgrade, lowest free slot otherwise
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      if (kind_in == KIND_UPGRADE) begin
        leaf[j].valid = ent[j].valid && (ent[j].tag == tag);
        leaf[j].key   = {ent[j].stamp, ent[j].slot};
        leaf[j].prio  = ent[j].prio;
      end else begin
        leaf[j].valid = !used[j];
        leaf[j].key   = KEY_BITS'(j);
        leaf[j].prio  = '0;
      end
    end
  end

  ftpq_min_tree u_tree (
    .clk  (clk),
    .load (accept),
    .leaf (leaf),
    .root (root)
  );

  assign cell_ctrl.op      = cell_op;
  assign cell_ctrl.upgrade = (kind_q == KIND_UPGRADE);
  assign cell_ctrl.ent     = new_ent;
  assign cell_ctrl.old_key = old_key_q;

  always_comb begin
    state_next = state;
    cell_op    = CELL_HOLD;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (kind_in)
            KIND_INSERT:  state_next = (count == COUNT_BITS'(DEPTH)) ? S_RESULT : S_SEARCH;
            KIND_REMOVE:  state_next = (count == '0) ? S_RESULT : S_APPLY;
            KIND_UPGRADE: state_next = S_SEARCH;
            KIND_CLEAR:   state_next = S_APPLY;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_SEARCH: begin
        if (srch == SRCH_BITS'(LEVELS - 1)) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (kind_q == KIND_UPGRADE && (!root.valid || root.prio < prio_q)) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_FLAG;
        end
      end
      S_FLAG: begin
        cell_op    = CELL_FLAG;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        unique case (kind_q)
          KIND_REMOVE: cell_op = CELL_REMOVE;
          KIND_CLEAR:  cell_op = CELL_CLEAR;
          default:     cell_op = CELL_APPLY;
        endcase
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      used      <= '0;
      count     <= '0;
      arrival   <= '0;
      srch      <= '0;
    end else begin
      state <= state_next;
      if (state == S_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_q    <= kind_in;
            tag_q     <= tag;
            prio_q    <= priority_req;
            removed_q <= '0;
            srch      <= '0;
            if (kind_in == KIND_INSERT && count == COUNT_BITS'(DEPTH)) begin
              status_q <= ST_FULL;
            end else if (kind_in == KIND_REMOVE && count == '0) begin
              status_q <= ST_EMPTY;
            end else begin
              status_q <= ST_OK;
            end
          end
        end
        S_SEARCH: srch <= srch + 1'b1;
        S_DECIDE: begin
          if (kind_q == KIND_UPGRADE) begin
            if (!root.valid) begin
              status_q <= ST_NOTAG;
            end else if (root.prio < prio_q) begin
              status_q <= ST_URGENT;
            end
            new_ent.stamp <= root.key[KEY_BITS-1:SLOT_BITS];
          end else begin
            new_ent.stamp <= arrival;
          end
          new_ent.valid <= 1'b1;
          new_ent.tag   <= tag_q;
          new_ent.prio  <= prio_q;
          new_ent.slot  <= root.key[SLOT_BITS-1:0];
          old_key_q     <= {root.prio, root.key};
        end
        S_APPLY: begin
          case (kind_q)
            KIND_INSERT: begin
              used[new_ent.slot] <= 1'b1;
              count              <= count + 1'b1;
              arrival            <= arrival + 1'b1;
            end
            KIND_REMOVE: begin
              used[ent[0].slot] <= 1'b0;
              count             <= count - 1'b1;
              removed_q         <= ent[0].tag;
            end
            KIND_CLEAR: begin
              used  <= '0;
              count <= '0;
            end
            default: ;
          endcase
        end
        S_RESULT: begin
          if (out_free) begin
            status         <= status_q;
            removed_tag    <= removed_q;
            front_tag      <= ent[0].valid ? ent[0].tag : '0;
            front_priority <= ent[0].valid ? ent[0].prio : '0;
            queue_empty    <= (count == '0);
            entry_count    <= count;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ design/ftpq_checker.sv @@
// ----------------------------------------------------------------------------
// ftpq_checker
// port-level checks on the result channel of the queue
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ftpq_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [ftpq_pkg::STATUS_BITS-1:0] status,
  input logic [ftpq_pkg::TAG_BITS-1:0]    removed_tag,
  input logic [ftpq_pkg::TAG_BITS-1:0]    front_tag,
  input logic [ftpq_pkg::PRIO_BITS-1:0]   front_priority,
  input logic                             queue_empty,
  input logic [ftpq_pkg::COUNT_BITS-1:0]  entry_count
);
  import ftpq_pkg::*;

  `ASSERT_SAME(a_empty_count, clk, rst, out_valid, queue_empty == (entry_count == '0))
  `ASSERT_SAME(a_empty_front, clk, rst, out_valid && queue_empty, front_tag == '0 && front_priority == '0)
  `ASSERT_SAME(a_full_count, clk, rst, out_valid && status == ST_FULL, entry_count == COUNT_BITS'(DEPTH))
  `ASSERT_SAME(a_empty_remove, clk, rst, out_valid && status == ST_EMPTY, queue_empty && removed_tag == '0)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(entry_count))

endmodule

bind fifo_tiebreak_priority_queue ftpq_checker u_ftpq_checker (.*);
